// File: design/sic_pkg.sv
package sic_pkg;

  localparam int unsigned WordBits = 16;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned SeqBits  = 32;

  localparam logic [ByteBits-1:0] DataLimitReset = 8'd80;

  // command field codes
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  typedef struct packed {
    logic                command;
    logic [WordBits-1:0] opcode;
    logic [SeqBits-1:0]  seq_ack;
    logic [ByteBits-1:0] data_byte;
    logic                last;
  } sic_item_t;

  // 16-bit ones'-complement add with end-around carry
  function automatic logic [WordBits-1:0] oc_add(input logic [WordBits-1:0] a,
                                                 input logic [WordBits-1:0] b);
    logic [WordBits:0] s;
    logic [WordBits:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[WordBits-1:0]} + {{WordBits{1'b0}}, s[WordBits]};
    return f[WordBits-1:0];
  endfunction

endpackage

// File: design/sic_accum.sv
module sic_accum import sic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  sic_item_t           item_i,
  input  logic [ByteBits-1:0] data_limit_i,
  output logic [WordBits-1:0] checksum_o
);

  logic [WordBits-1:0] sum_acc_q, sum_acc_d;
  logic [ByteBits-1:0] pending_byte_q, pending_byte_d;
  logic                pending_valid_q, pending_valid_d;
  logic [ByteBits-1:0] byte_count_q, byte_count_d;
  logic                stopped_q, stopped_d;
  logic [WordBits-1:0] total;

  always_comb begin
    sum_acc_d       = sum_acc_q;
    pending_byte_d  = pending_byte_q;
    pending_valid_d = pending_valid_q;
    byte_count_d    = byte_count_q;
    stopped_d       = stopped_q;
    if (accept_i) begin
      if (item_i.command == CMD_HEADER) begin
        sum_acc_d       = oc_add(oc_add(item_i.opcode, item_i.seq_ack[WordBits-1:0]),
                                 item_i.seq_ack[SeqBits-1:WordBits]);
        pending_byte_d  = '0;
        pending_valid_d = 1'b0;
        byte_count_d    = '0;
        stopped_d       = 1'b0;
      end else if (!stopped_q) begin
        // zero byte ends the string; limit reached ends accumulation
        if (item_i.data_byte == '0 || byte_count_q >= data_limit_i) begin
          stopped_d = 1'b1;
        end else begin
          byte_count_d = byte_count_q + ByteBits'(1);
          if (pending_valid_q) begin
            sum_acc_d       = oc_add(sum_acc_q, {item_i.data_byte, pending_byte_q});
            pending_byte_d  = '0;
            pending_valid_d = 1'b0;
          end else begin
            pending_byte_d  = item_i.data_byte;
            pending_valid_d = 1'b1;
          end
        end
      end
    end
  end

  // odd leftover byte goes in as a low byte
  assign total      = pending_valid_d ? oc_add(sum_acc_d, {{ByteBits{1'b0}}, pending_byte_d})
                                      : sum_acc_d;
  assign checksum_o = ~total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_acc_q       <= '0;
      pending_byte_q  <= '0;
      pending_valid_q <= 1'b0;
      byte_count_q    <= '0;
      stopped_q       <= 1'b0;
    end else begin
      sum_acc_q       <= sum_acc_d;
      pending_byte_q  <= pending_byte_d;
      pending_valid_q <= pending_valid_d;
      byte_count_q    <= byte_count_d;
      stopped_q       <= stopped_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_header_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.command == CMD_HEADER |=>
      byte_count_q == '0 && !stopped_q && !pending_valid_q)
    else $error("header did not clear segment state");

  a_pending_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_valid_q |-> pending_byte_q == '0)
    else $error("stale pending byte");

  a_stopped_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.command == CMD_DATA && stopped_q |=>
      stopped_q && byte_count_q == $past(byte_count_q) && sum_acc_q == $past(sum_acc_q))
    else $error("data changed state after stop");
`endif

endmodule

// File: design/segment_internet_checksum_top.sv
// Internet checksum of a segment, one item per beat.
// The result is registered in the output register, or the skid register while stalled.
// Throughput: one item per cycle while in_stall_o is low; adds are 16-bit end-around-carry.
// A one-entry skid register holds a result while the output beat is stalled.
// Reset (rst_ni low, async): sum, pending byte, count, stop flag and valids clear;
// data_limit returns to 80.
module segment_internet_checksum_top import sic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: data_limit write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ByteBits-1:0] cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_command_i,
  input  logic [WordBits-1:0] in_opcode_i,
  input  logic [SeqBits-1:0]  in_seq_ack_i,
  input  logic [ByteBits-1:0] in_data_byte_i,
  input  logic                in_last_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordBits-1:0] out_checksum_o
);

  logic [ByteBits-1:0] data_limit_q;
  logic                in_accept;
  sic_item_t           item;
  logic [WordBits-1:0] checksum_next;

  logic                out_valid_q;
  logic [WordBits-1:0] out_data_q;
  logic                skid_valid_q;
  logic [WordBits-1:0] skid_data_q;
  logic                out_free;
  logic                new_result;

  // the block is always ready for a configuration beat
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_limit_q <= DataLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      data_limit_q <= cfg_data_i;
    end
  end

  // Input is held off only while the skid entry is occupied.
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign item = '{command:   in_command_i,
                  opcode:    in_opcode_i,
                  seq_ack:   in_seq_ack_i,
                  data_byte: in_data_byte_i,
                  last:      in_last_i};

  sic_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (item),
    .data_limit_i(data_limit_q),
    .checksum_o  (checksum_next)
  );

  assign new_result = in_accept && item.last;
  // output register can take a value this edge
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        // skid drains first; a new result can only arrive when skid is empty
        out_valid_q  <= skid_valid_q || new_result;
        skid_valid_q <= 1'b0;
      end else if (new_result) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : checksum_next;
    end
    if (!out_free && new_result) begin
      skid_data_q <= checksum_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_checksum_o = out_data_q;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result ahead of the output register");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_result |=> out_valid_q)
    else $error("last item produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !new_result && !skid_valid_q && !(out_valid_q && out_stall_i) |=> !out_valid_q)
    else $error("result without a last item");
`endif

endmodule

// File: verif/segment_internet_checksum_top_tb.sv
module segment_internet_checksum_top_tb;
  import sic_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // give up well past the slowest legal run (~500 beats)
  localparam int unsigned CycleLimit = 200000;
  // beats the random part aims for, directed rows and the long segment excluded
  localparam int unsigned RandomBeats = 160;

  // Clock, reset and DUT ports. Every input starts at a known value.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [ByteBits-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                in_command_i   = CMD_HEADER;
  logic [WordBits-1:0] in_opcode_i    = '0;
  logic [SeqBits-1:0]  in_seq_ack_i   = '0;
  logic [ByteBits-1:0] in_data_byte_i = '0;
  logic                in_last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [WordBits-1:0] out_checksum_o;

  segment_internet_checksum_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_command_i   (in_command_i),
    .in_opcode_i    (in_opcode_i),
    .in_seq_ack_i   (in_seq_ack_i),
    .in_data_byte_i (in_data_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_checksum_o (out_checksum_o)
  );

  // 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Checksum predictor: a private copy of the segment state and of data_limit.
  // ---------------------------------------------------------------------------
  logic [WordBits-1:0] run_sum    = '0;
  logic [ByteBits-1:0] held_byte  = '0;   // first byte of an open pair
  logic                held_ok    = 1'b0;
  logic [ByteBits-1:0] byte_tally = '0;   // payload bytes taken this segment
  logic [ByteBits-1:0] byte_cap   = DataLimitReset;
  logic                halted     = 1'b0; // string end or limit seen

  // checksums owed by the DUT, oldest first
  logic [WordBits-1:0] pending_sums[$];

  int unsigned mismatches = 0;
  int unsigned item_total = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;   // when set, neither side idles

  // 16-bit add with the carry wrapped back into bit 0
  function automatic logic [WordBits-1:0] fold_add(input logic [WordBits-1:0] a,
                                                   input logic [WordBits-1:0] b);
    logic [WordBits:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[WordBits-1:0] + WordBits'(wide[WordBits]);
  endfunction

  // Advances the predictor by one beat. Returns 1 when the beat emits a
  // checksum, which is then in cs.
  function automatic bit checksum_step(input sic_item_t it, output logic [WordBits-1:0] cs);
    logic [WordBits-1:0] total;
    if (it.command == CMD_HEADER) begin
      // header restarts the segment: opcode plus both halves of seq/ack
      run_sum    = fold_add(fold_add(it.opcode, it.seq_ack[WordBits-1:0]),
                            it.seq_ack[SeqBits-1:WordBits]);
      held_byte  = '0;
      held_ok    = 1'b0;
      byte_tally = '0;
      halted     = 1'b0;
    end else if (!halted) begin
      if (it.data_byte == '0 || byte_tally >= byte_cap) begin
        halted = 1'b1;
      end else begin
        byte_tally = byte_tally + ByteBits'(1);
        if (held_ok) begin
          // little-endian pair: earlier byte low, this one high
          run_sum   = fold_add(run_sum, {it.data_byte, held_byte});
          held_byte = '0;
          held_ok   = 1'b0;
        end else begin
          held_byte = it.data_byte;
          held_ok   = 1'b1;
        end
      end
    end
    // an odd byte joins only the emitted copy, never the running sum
    total = held_ok ? fold_add(run_sum, {{ByteBits{1'b0}}, held_byte}) : run_sum;
    cs = ~total;
    return it.last;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic sic_item_t junk_item();
    sic_item_t it;
    it.command   = 1'($urandom_range(0, 1));
    it.opcode    = WordBits'($urandom_range(0, 16'hFFFF));
    it.seq_ack   = $urandom;
    it.data_byte = ByteBits'($urandom_range(0, 255));
    it.last      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Drives one beat and waits for it to be taken. A typed checksum, when
  // given, replaces the predicted one in the expectation queue.
  task automatic send_item(input sic_item_t it, input bit typed = 1'b0,
                           input logic [WordBits-1:0] want = '0);
    int unsigned         gap;
    logic [WordBits-1:0] cs;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_command_i   <= it.command;
    in_opcode_i    <= it.opcode;
    in_seq_ack_i   <= it.seq_ack;
    in_data_byte_i <= it.data_byte;
    in_last_i      <= it.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_total++;
    if (checksum_step(it, cs)) pending_sums.push_back(typed ? want : cs);
  endtask

  // Sender holds off until every owed checksum is out, then waits on so that
  // a data beat that produced no result can finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // data_limit write, only with the block idle
  task automatic set_limit(input logic [ByteBits-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    byte_cap = value;
  endtask

  // One random stretch: mostly a well-formed segment (header, nonzero bytes,
  // last on the final one), sometimes continuing the open segment without a
  // header, with an early string end, or a burst of arbitrary beats.
  task automatic random_segment();
    sic_item_t   it;
    int unsigned len;
    int          cut;
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) send_item(junk_item());
    end else begin
      if ($urandom_range(0, 4) != 0) begin
        it         = junk_item();
        it.command = CMD_HEADER;
        it.last    = ($urandom_range(0, 5) == 0);
        send_item(it);
      end
      len = $urandom_range(0, 7);
      // now and then run past the byte limit
      if ($urandom_range(0, 11) == 0 && byte_cap < 100) len = byte_cap + $urandom_range(0, 3);
      cut = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, len)) : -1;
      if (len == 0) begin
        it           = junk_item();
        it.command   = CMD_DATA;
        it.data_byte = '0;
        it.last      = 1'b1;
        send_item(it);
      end
      for (int i = 0; i < len; i++) begin
        it           = junk_item();
        it.command   = CMD_DATA;
        it.data_byte = (i == cut) ? '0 : ByteBits'($urandom_range(1, 255));
        it.last      = (i == len - 1) || ($urandom_range(0, 9) == 0);
        send_item(it);
      end
    end
  endtask

  task automatic random_phase(input int unsigned beats);
    int unsigned goal;
    goal = item_total + beats;
    while (item_total < goal) random_segment();
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    sic_item_t           item;
    bit                  typed;   // want holds a hand-worked checksum
    logic [WordBits-1:0] want;
  } vector_row_t;

  function automatic vector_row_t vec(input logic cmd, input logic [WordBits-1:0] op,
                                      input logic [SeqBits-1:0] seq,
                                      input logic [ByteBits-1:0] b, input logic last,
                                      input bit typed = 1'b0,
                                      input logic [WordBits-1:0] want = '0);
    vector_row_t r;
    r.item.command   = cmd;
    r.item.opcode    = op;
    r.item.seq_ack   = seq;
    r.item.data_byte = b;
    r.item.last      = last;
    r.typed          = typed;
    r.want           = want;
    return r;
  endfunction

  vector_row_t directed[$];

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sic_item_t it;

    // data before any header rides on the reset state
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h12, 1'b1, 1'b1, 16'hFFED));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h34, 1'b1, 1'b1, 16'hCBED));
    // string end, then a byte that must be ignored
    directed.push_back(vec(CMD_DATA, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 16'hCBED));
    directed.push_back(vec(CMD_DATA, 16'hFFFF, 32'hFFFF_FFFF, 8'h77, 1'b1, 1'b1, 16'hCBED));
    // header extremes
    directed.push_back(vec(CMD_HEADER, 16'h0000, 32'h0000_0000, 8'hFF, 1'b1, 1'b1, 16'hFFFF));
    directed.push_back(vec(CMD_HEADER, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 16'h0000));
    // odd byte on an all-ones sum, then close the pair
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'hFF, 1'b1));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h01, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h80, 1'b1));
    // short string with leftover byte, string end, byte after stop
    directed.push_back(vec(CMD_HEADER, 16'h1234, 32'hDEAD_BEEF, 8'h00, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h41, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h42, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h43, 1'b1));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'hFF, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h00, 1'b1));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h10, 1'b1));
    // end-around carry out of the header words
    directed.push_back(vec(CMD_HEADER, 16'h8000, 32'h8000_8000, 8'h01, 1'b1));
    // all-ones pairs
    directed.push_back(vec(CMD_HEADER, 16'hA5A5, 32'h5A5A_5A5A, 8'h55, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    directed.push_back(vec(CMD_DATA, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0));
    directed.push_back(vec(CMD_DATA, 16'h0000, 32'h0000_0000, 8'h01, 1'b1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset limit of 80
    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].want);
    random_phase(RandomBeats * 3 / 10);

    // limit 0: any payload byte stops the segment; the open segment
    // continues across the write, so the new limit hits it mid-stream
    set_limit(8'd0);
    random_phase(RandomBeats / 10);

    set_limit(8'd1);
    random_phase(RandomBeats / 10);

    // widest limit, with one segment long enough to run into it
    set_limit(8'd255);
    calm = 1'b0;
    it         = junk_item();
    it.command = CMD_HEADER;
    it.last    = 1'b0;
    send_item(it);
    for (int i = 0; i < 258; i++) begin
      it           = junk_item();
      it.command   = CMD_DATA;
      it.data_byte = ByteBits'($urandom_range(1, 255));
      it.last      = (i == 257) || (i == 254);
      send_item(it);
    end
    random_phase(RandomBeats / 10);

    set_limit(ByteBits'($urandom_range(3, 254)));
    random_phase(RandomBeats * 2 / 10);

    set_limit(DataLimitReset);
    random_phase(RandomBeats * 2 / 10);

    // drain, then give the last beat time to show up
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, one stall draw per result beat
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Result checker: every beat taken is matched to the oldest owed checksum.
  logic [WordBits-1:0] want_sum;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: checksum %h", out_checksum_o);
      end else begin
        want_sum = pending_sums.pop_front();
        if (out_checksum_o !== want_sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checksum mismatch: expected %h, got %h", want_sum, out_checksum_o);
        end
      end
    end
  end

  // Watchdog: covers a hung handshake and results that never arrive.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
